>>> hdl/lprt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page replacement tracker package
// Command and status codes shared by the channel interfaces and the tracker.
// ----------------------------------------------------------------------------
package lprt_pkg;

   // Field widths that are fixed by the request and response formats.
   localparam int CMD_BITS    = 2;
   localparam int STATUS_BITS = 3;

   // Request commands. The fourth code has no meaning.
   typedef enum logic [CMD_BITS-1:0] {
      CMD_INSERT = 2'd0,
      CMD_TOUCH  = 2'd1,
      CMD_EVICT  = 2'd2
   } cmd_type;

   // Response status codes.
   typedef enum logic [STATUS_BITS-1:0] {
      STAT_INSERTED = 3'd0,
      STAT_UPDATED  = 3'd1,
      STAT_TOUCHED  = 3'd2,
      STAT_NOTFOUND = 3'd3,
      STAT_EVICTED  = 3'd4,
      STAT_EMPTY    = 3'd5,
      STAT_FULL     = 3'd6
   } status_type;

endpackage

>>> hdl/lprt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page replacement tracker channels
// Valid/ready request and response channels with source and sink modports.
// ----------------------------------------------------------------------------

// Request channel: one command with its page number and frame handle.
interface lprt_req_if #(
   parameter int KEY_BITS   = 20,
   parameter int FRAME_BITS = 16
);
   import lprt_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CMD_BITS-1:0]   command;
   logic [KEY_BITS-1:0]   page_key;
   logic [FRAME_BITS-1:0] frame_value;

   modport source (output valid, command, page_key, frame_value, input ready);
   modport sink   (input valid, command, page_key, frame_value, output ready);
endinterface

// Response channel: status, evicted pair and occupancy after the request.
interface lprt_rsp_if #(
   parameter int KEY_BITS   = 20,
   parameter int FRAME_BITS = 16,
   parameter int OCC_BITS   = 5
);
   import lprt_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [STATUS_BITS-1:0] status;
   logic [KEY_BITS-1:0]    out_key;
   logic [FRAME_BITS-1:0]  out_frame;
   logic [OCC_BITS-1:0]    occupancy;

   modport source (output valid, status, out_key, out_frame, occupancy, input ready);
   modport sink   (input valid, status, out_key, out_frame, occupancy, output ready);
endinterface

>>> hdl/lru_page_replacement_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page replacement tracker
// Holds up to ENTRIES page/frame pairs in recency order with insert, touch
// and evict commands.
// ----------------------------------------------------------------------------
// The sequencer walks the slots one per cycle through the single read port of
// the key and frame memories, comparing keys or looking for the oldest rank.
// It then waits until the output register is free, applies the update to all
// recency ranks at once and writes the response to the output register. The
// request side is ready only while the sequencer is idle; a finished response
// may still wait in the output register while the next request is scanned.
// The response interface must be built with OCC_BITS = $clog2(ENTRIES + 1)
// and both interfaces with the same KEY_BITS and FRAME_BITS as this block.
module lru_page_replacement_tracker #(
   parameter int ENTRIES    = 16,
   parameter int KEY_BITS   = 20,
   parameter int FRAME_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   lprt_req_if.sink   req_bus,
   lprt_rsp_if.source rsp_bus
);
   import lprt_pkg::*;

   localparam int ADDR_BITS = $clog2(ENTRIES);
   localparam int RANK_BITS = ADDR_BITS;
   localparam int CNT_BITS  = $clog2(ENTRIES + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE
   } state_type;

   // Sequencer and bookkeeping registers.
   state_type             state_ff, state_in;
   logic [CNT_BITS-1:0]   scan_cnt_ff, scan_cnt_in;
   logic                  cmp_vld_ff, cmp_vld_in;
   logic [ADDR_BITS-1:0]  cmp_idx_ff, cmp_idx_in;
   cmd_type               cmd_ff, cmd_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [FRAME_BITS-1:0] frame_ff, frame_in;
   logic                  hit_ff, hit_in;
   logic [ADDR_BITS-1:0]  hit_slot_ff, hit_slot_in;
   logic [RANK_BITS-1:0]  hit_rank_ff, hit_rank_in;
   logic [KEY_BITS-1:0]   hit_key_ff, hit_key_in;
   logic [FRAME_BITS-1:0] hit_frame_ff, hit_frame_in;
   logic                  free_ff, free_in;
   logic [ADDR_BITS-1:0]  free_slot_ff, free_slot_in;

   // Per-slot state: valid bits and the rotating line of recency ranks.
   logic [ENTRIES-1:0]    valid_ff, valid_in;
   logic [RANK_BITS-1:0]  rank_ff [ENTRIES];
   logic [RANK_BITS-1:0]  rank_in [ENTRIES];
   logic [CNT_BITS-1:0]   count_ff, count_in;

   // Response register.
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [KEY_BITS-1:0]   rsp_key_ff, rsp_key_in;
   logic [FRAME_BITS-1:0] rsp_frame_ff, rsp_frame_in;
   logic [CNT_BITS-1:0]   rsp_occ_ff, rsp_occ_in;

   // Key and frame memories with a registered read port.
   logic [KEY_BITS-1:0]   key_mem   [ENTRIES];
   logic [FRAME_BITS-1:0] frame_mem [ENTRIES];
   logic [KEY_BITS-1:0]   key_rd_ff;
   logic [FRAME_BITS-1:0] frame_rd_ff;
   logic [ADDR_BITS-1:0]  rd_addr;
   logic [ADDR_BITS-1:0]  wr_addr;
   logic                  key_we;
   logic                  frame_we;
   logic [KEY_BITS-1:0]   wr_key;
   logic [FRAME_BITS-1:0] wr_frame;

   logic [CNT_BITS-1:0]   oldest_rank;
   logic                  slot_match;
   logic                  commit;

   assign rd_addr     = scan_cnt_ff[ADDR_BITS-1:0];
   assign oldest_rank = count_ff - CNT_BITS'(1);
   assign commit      = !rsp_valid_ff || rsp_bus.ready;

   // The slot under compare is a match for the current command.
   always_comb begin
      if (cmd_ff == CMD_EVICT) begin
         slot_match = valid_ff[cmp_idx_ff] && (CNT_BITS'(rank_ff[0]) == oldest_rank);
      end else begin
         slot_match = valid_ff[cmp_idx_ff] && (key_rd_ff == key_ff);
      end
   end

   // Sequencer next-state logic.
   always_comb begin
      state_in      = state_ff;
      scan_cnt_in   = scan_cnt_ff;
      cmp_vld_in    = cmp_vld_ff;
      cmp_idx_in    = cmp_idx_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      frame_in      = frame_ff;
      hit_in        = hit_ff;
      hit_slot_in   = hit_slot_ff;
      hit_rank_in   = hit_rank_ff;
      hit_key_in    = hit_key_ff;
      hit_frame_in  = hit_frame_ff;
      free_in       = free_ff;
      free_slot_in  = free_slot_ff;
      valid_in      = valid_ff;
      rank_in       = rank_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_frame_in  = rsp_frame_ff;
      rsp_occ_in    = rsp_occ_ff;
      wr_addr       = hit_slot_ff;
      key_we        = 1'b0;
      frame_we      = 1'b0;
      wr_key        = key_ff;
      wr_frame      = frame_ff;

      // A taken response frees the output register.
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               cmd_in      = cmd_type'(req_bus.command);
               key_in      = req_bus.page_key;
               frame_in    = req_bus.frame_value;
               scan_cnt_in = '0;
               cmp_vld_in  = 1'b0;
               hit_in      = 1'b0;
               free_in     = 1'b0;
               state_in    = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // Issue one slot address a cycle; the compare follows in the next cycle.
            if (scan_cnt_ff < CNT_BITS'(ENTRIES)) begin
               cmp_vld_in  = 1'b1;
               cmp_idx_in  = rd_addr;
               scan_cnt_in = scan_cnt_ff + CNT_BITS'(1);
            end else begin
               cmp_vld_in = 1'b0;
               state_in   = ST_UPDATE;
            end

            if (cmp_vld_ff) begin
               // The head of the rank line always holds the slot under compare.
               for (int i = 0; i < ENTRIES; i++) begin
                  rank_in[i] = rank_ff[(i + 1) % ENTRIES];
               end
               if (slot_match && !hit_ff) begin
                  hit_in       = 1'b1;
                  hit_slot_in  = cmp_idx_ff;
                  hit_rank_in  = rank_ff[0];
                  hit_key_in   = key_rd_ff;
                  hit_frame_in = frame_rd_ff;
               end
               if (!valid_ff[cmp_idx_ff] && !free_ff) begin
                  free_in      = 1'b1;
                  free_slot_in = cmp_idx_ff;
               end
            end
         end

         ST_UPDATE: begin
            if (commit) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_NOTFOUND;
               rsp_key_in    = '0;
               rsp_frame_in  = '0;
               state_in      = ST_IDLE;

               unique case (cmd_ff)
                  CMD_INSERT: begin
                     if (hit_ff) begin
                        // Present page: new frame and move to the front.
                        frame_we      = 1'b1;
                        rsp_status_in = STAT_UPDATED;
                        for (int i = 0; i < ENTRIES; i++) begin
                           if (ADDR_BITS'(i) == hit_slot_ff) begin
                              rank_in[i] = '0;
                           end else if (valid_ff[i] && (rank_ff[i] < hit_rank_ff)) begin
                              rank_in[i] = rank_ff[i] + RANK_BITS'(1);
                           end
                        end
                     end else if ((count_ff >= CNT_BITS'(ENTRIES)) || !free_ff) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        // New page in the lowest free slot; every other valid entry ages.
                        wr_addr       = free_slot_ff;
                        key_we        = 1'b1;
                        frame_we      = 1'b1;
                        valid_in[free_slot_ff] = 1'b1;
                        count_in      = count_ff + CNT_BITS'(1);
                        rsp_status_in = STAT_INSERTED;
                        for (int i = 0; i < ENTRIES; i++) begin
                           if (ADDR_BITS'(i) == free_slot_ff) begin
                              rank_in[i] = '0;
                           end else if (valid_ff[i]) begin
                              rank_in[i] = rank_ff[i] + RANK_BITS'(1);
                           end
                        end
                     end
                  end

                  CMD_TOUCH: begin
                     if (hit_ff) begin
                        rsp_status_in = STAT_TOUCHED;
                        for (int i = 0; i < ENTRIES; i++) begin
                           if (ADDR_BITS'(i) == hit_slot_ff) begin
                              rank_in[i] = '0;
                           end else if (valid_ff[i] && (rank_ff[i] < hit_rank_ff)) begin
                              rank_in[i] = rank_ff[i] + RANK_BITS'(1);
                           end
                        end
                     end
                  end

                  CMD_EVICT: begin
                     if ((count_ff != '0) && hit_ff) begin
                        valid_in[hit_slot_ff] = 1'b0;
                        rank_in[hit_slot_ff]  = '0;
                        count_in              = count_ff - CNT_BITS'(1);
                        rsp_status_in         = STAT_EVICTED;
                        rsp_key_in            = hit_key_ff;
                        rsp_frame_in          = hit_frame_ff;
                     end else begin
                        rsp_status_in = STAT_EMPTY;
                     end
                  end

                  default: begin
                     rsp_status_in = STAT_NOTFOUND;
                  end
               endcase

               rsp_occ_in = count_in;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_cnt_ff  <= '0;
         cmp_vld_ff   <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         valid_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         scan_cnt_ff  <= scan_cnt_in;
         cmp_vld_ff   <= cmp_vld_in;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         rank_ff      <= rank_in;
      end
      cmp_idx_ff    <= cmp_idx_in;
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      frame_ff      <= frame_in;
      hit_slot_ff   <= hit_slot_in;
      hit_rank_ff   <= hit_rank_in;
      hit_key_ff    <= hit_key_in;
      hit_frame_ff  <= hit_frame_in;
      free_slot_ff  <= free_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_frame_ff  <= rsp_frame_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   // Key and frame memories: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[wr_addr] <= wr_key;
      end
      if (frame_we) begin
         frame_mem[wr_addr] <= wr_frame;
      end
      key_rd_ff   <= key_mem[rd_addr];
      frame_rd_ff <= frame_mem[rd_addr];
   end

   // Channel outputs.
   assign req_bus.ready     = (state_ff == ST_IDLE);
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.status    = rsp_status_ff;
   assign rsp_bus.out_key   = rsp_key_ff;
   assign rsp_bus.out_frame = rsp_frame_ff;
   assign rsp_bus.occupancy = rsp_occ_ff;

   // The fill count always agrees with the valid bits.
   a_count_matches_valid: assert property (
      @(posedge clock) disable iff (reset)
      $countones(valid_ff) == 32'(count_ff)
   ) else $error("entry count differs from the number of valid slots");

   // The store never holds more than its capacity.
   a_count_in_range: assert property (
      @(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(ENTRIES)
   ) else $error("entry count exceeds capacity");

   // A response appears only out of the update step.
   a_rsp_from_update: assert property (
      @(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_UPDATE)
   ) else $error("response raised outside the update step");

endmodule
